### rtl/core/lavb_pkg.sv
// ----------------------------------------------------------------------------
// lavb_pkg
// shared widths, payload types and the rescale helper of the look-at view basis
// ----------------------------------------------------------------------------
package lavb_pkg;

   localparam int CoordWidth   = 32;
   localparam int UnitFracBits = 30;
   localparam int UnitWidth    = UnitFracBits + 2;
   localparam int PrescaleTop  = 29;
   localparam int ScaleWidth   = PrescaleTop + 2;          // signed rescaled component
   localparam int CrossWidth   = 2 * ScaleWidth + 1;       // exact cross product term
   localparam int SumWidth     = 2 * PrescaleTop + 4;      // sum of three squares
   localparam int LenWidth     = SumWidth / 2;
   localparam int QuotWidth    = UnitFracBits + 2;
   localparam int ReqWidth     = 9 * CoordWidth;
   localparam int RspWidth     = 9 * UnitWidth + 3 * CoordWidth;
   localparam int QueueDepth   = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [ScaleWidth-1:0] scaled_type;
   typedef logic signed [UnitWidth-1:0]  unit_type;

   typedef struct packed {
      coord_type [2:0] eye;
      coord_type [2:0] ctr;
      coord_type [2:0] up;
   } req_type;

   typedef struct packed {
      scaled_type [2:0] zs;
      scaled_type [2:0] us;
      coord_type  [2:0] shift;
   } front_type;

   typedef struct packed {
      unit_type  [2:0] side;
      unit_type  [2:0] upaxis;
      unit_type  [2:0] view;
      coord_type [2:0] shift;
   } rsp_type;

   // block rescale of a vector of signed magnitudes, top bit lands at PrescaleTop
   function automatic logic [ScaleWidth*3-1:0] rescale_vec(
      input logic signed [CrossWidth-1:0] v0,
      input logic signed [CrossWidth-1:0] v1,
      input logic signed [CrossWidth-1:0] v2);
      logic [CrossWidth-1:0] a [3];
      logic [CrossWidth-1:0] m;
      logic [CrossWidth-1:0] s;
      logic [ScaleWidth-1:0] r [3];
      int p;
      a[0] = v0[CrossWidth-1] ? -v0 : v0;
      a[1] = v1[CrossWidth-1] ? -v1 : v1;
      a[2] = v2[CrossWidth-1] ? -v2 : v2;
      m = a[0] | a[1] | a[2];
      p = 0;
      for (int b = 0; b < CrossWidth; b++) begin
         if (m[b]) p = b;
      end
      for (int i = 0; i < 3; i++) begin
         if (p > PrescaleTop) s = a[i] >> (p - PrescaleTop);
         else s = a[i] << (PrescaleTop - p);
         r[i] = s[ScaleWidth-1:0];
      end
      rescale_vec = {(v2[CrossWidth-1] ? -r[2] : r[2]),
                     (v1[CrossWidth-1] ? -r[1] : r[1]),
                     (v0[CrossWidth-1] ? -r[0] : r[0])};
   endfunction

endpackage

### rtl/core/lavb_front.sv
// ----------------------------------------------------------------------------
// lavb_front
// forms the view axis, rescales view and up, saturates the shift
// ----------------------------------------------------------------------------
module lavb_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  lavb_pkg::req_type   in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output lavb_pkg::front_type out_data
);
   import lavb_pkg::*;

   logic      valid_ff, valid_in;
   front_type data_ff, data_in;
   logic signed [CrossWidth-1:0] z [3];
   logic signed [CrossWidth-1:0] u [3];

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         z[i] = CrossWidth'(in_data.eye[i]) - CrossWidth'(in_data.ctr[i]);
         u[i] = CrossWidth'(in_data.up[i]);
         if (in_data.eye[i] == {1'b1, {(CoordWidth-1){1'b0}}})
            data_in.shift[i] = {1'b0, {(CoordWidth-1){1'b1}}};
         else
            data_in.shift[i] = -in_data.eye[i];
      end
      data_in.zs = rescale_vec(z[0], z[1], z[2]);
      data_in.us = rescale_vec(u[0], u[1], u[2]);
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (in_ready && in_valid) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

### rtl/core/lavb_queue.sv
// ----------------------------------------------------------------------------
// lavb_queue
// short queue between the front and back parts
// ----------------------------------------------------------------------------
module lavb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  lavb_pkg::front_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output lavb_pkg::front_type out_data
);
   import lavb_pkg::*;

   front_type mem [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QueuePtrWidth:0]   cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready  = cnt_ff != (QueuePtrWidth+1)'(QueueDepth);
   assign out_valid = cnt_ff != '0;
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   assign out_data = mem[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QueuePtrWidth+1)'(push) - (QueuePtrWidth+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem[wr_ff] <= in_data;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QueuePtrWidth+1)'(QueueDepth))
      else $error("queue count overflow");
   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count did not grow");
   a_pop_shrink: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("queue count did not shrink");
endmodule

### rtl/core/lavb_back.sv
// ----------------------------------------------------------------------------
// lavb_back
// cross products, rescales and unit scaling in a stall-together pipeline
// ----------------------------------------------------------------------------
module lavb_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  lavb_pkg::front_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output lavb_pkg::rsp_type   out_data
);
   import lavb_pkg::*;

   // stage a: x = us cross zs, y = zs cross xs
   typedef struct packed {
      scaled_type [2:0] zs;
      scaled_type [2:0] xs;
      scaled_type [2:0] ys;
      coord_type  [2:0] shift;
   } vec_type;

   logic adv;
   logic [1:0] v1_ff;
   front_type  f_ff;
   logic signed [CrossWidth-1:0] xp_ff [3][2];
   vec_type    b_ff;
   logic signed [CrossWidth-1:0] yp_ff [3][2];
   vec_type    c_ff;
   logic       vb_ff, vc_ff, vd_ff, ve_ff;
   logic signed [CrossWidth-1:0] xr [3];
   logic signed [CrossWidth-1:0] yr [3];
   logic [ScaleWidth*3-1:0] xsv, ysv;

   // squares and sums
   logic [SumWidth-1:0] sq_ff [3][3];
   vec_type d_ff;
   logic [SumWidth-1:0] sum_ff [3];
   vec_type e_ff;
   vec_type g_ff;

   // square-root and divide chains: one result bit per stage, three root lanes, nine divide lanes
   localparam int RootSteps = LenWidth;
   localparam int DivSteps  = QuotWidth;
   logic [SumWidth-1:0] rn_ff  [RootSteps+1][3];
   logic [SumWidth-1:0] rr_ff  [RootSteps+1][3];
   logic [SumWidth-1:0] rb_ff  [RootSteps+1][3];
   vec_type             rv_ff  [RootSteps+1];
   logic                rvl_ff [RootSteps+1];
   logic [LenWidth:0]   dr_ff  [DivSteps+1][9];
   logic [QuotWidth:0]  dq_ff  [DivSteps+1][9];
   logic [LenWidth-1:0] dl_ff  [DivSteps+1][3];
   logic [8:0]          dn_ff  [DivSteps+1];
   coord_type [2:0]     ds_ff  [DivSteps+1];
   logic                dvl_ff [DivSteps+1];

   logic     out_valid_ff;
   rsp_type  out_ff, out_in;

   assign adv      = !out_valid_ff || out_ready;
   assign in_ready = adv;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         xr[i] = xp_ff[i][0] - xp_ff[i][1];
         yr[i] = yp_ff[i][0] - yp_ff[i][1];
      end
      xsv = rescale_vec(xr[0], xr[1], xr[2]);
      ysv = rescale_vec(yr[0], yr[1], yr[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= '0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         for (int s = 0; s <= RootSteps; s++) rvl_ff[s] <= 1'b0;
         for (int s = 0; s <= DivSteps; s++) dvl_ff[s] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= {v1_ff[0], in_valid};
         vb_ff <= v1_ff[1];
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
         rvl_ff[0] <= ve_ff;
         for (int s = 1; s <= RootSteps; s++) rvl_ff[s] <= rvl_ff[s-1];
         dvl_ff[0] <= rvl_ff[RootSteps];
         for (int s = 1; s <= DivSteps; s++) dvl_ff[s] <= dvl_ff[s-1];
         out_valid_ff <= dvl_ff[DivSteps];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // cross product of us and zs
         f_ff <= in_data;
         xp_ff[0][0] <= CrossWidth'(in_data.us[1] * in_data.zs[2]);
         xp_ff[0][1] <= CrossWidth'(in_data.us[2] * in_data.zs[1]);
         xp_ff[1][0] <= CrossWidth'(in_data.us[2] * in_data.zs[0]);
         xp_ff[1][1] <= CrossWidth'(in_data.us[0] * in_data.zs[2]);
         xp_ff[2][0] <= CrossWidth'(in_data.us[0] * in_data.zs[1]);
         xp_ff[2][1] <= CrossWidth'(in_data.us[1] * in_data.zs[0]);
         // rescale x, hold for y products
         b_ff.zs    <= f_ff.zs;
         b_ff.xs    <= xsv;
         b_ff.ys    <= '0;
         b_ff.shift <= f_ff.shift;
         yp_ff[0][0] <= CrossWidth'(b_ff.zs[1] * b_ff.xs[2]);
         yp_ff[0][1] <= CrossWidth'(b_ff.zs[2] * b_ff.xs[1]);
         yp_ff[1][0] <= CrossWidth'(b_ff.zs[2] * b_ff.xs[0]);
         yp_ff[1][1] <= CrossWidth'(b_ff.zs[0] * b_ff.xs[2]);
         yp_ff[2][0] <= CrossWidth'(b_ff.zs[0] * b_ff.xs[1]);
         yp_ff[2][1] <= CrossWidth'(b_ff.zs[1] * b_ff.xs[0]);
         c_ff <= b_ff;
         d_ff.zs    <= c_ff.zs;
         d_ff.xs    <= c_ff.xs;
         d_ff.ys    <= ysv;
         d_ff.shift <= c_ff.shift;
         // squares per component, vector order: side, upaxis, view
         for (int i = 0; i < 3; i++) begin
            sq_ff[0][i] <= SumWidth'(d_ff.xs[i] * d_ff.xs[i]);
            sq_ff[1][i] <= SumWidth'(d_ff.ys[i] * d_ff.ys[i]);
            sq_ff[2][i] <= SumWidth'(d_ff.zs[i] * d_ff.zs[i]);
         end
         e_ff <= d_ff;
         for (int v = 0; v < 3; v++) sum_ff[v] <= sq_ff[v][0] + sq_ff[v][1] + sq_ff[v][2];
         g_ff <= e_ff;
         // square root, two bits of the radicand a stage
         rv_ff[0] <= g_ff;
         for (int v = 0; v < 3; v++) begin
            rn_ff[0][v] <= sum_ff[v];
            rr_ff[0][v] <= '0;
            rb_ff[0][v] <= SumWidth'(1) << (SumWidth - 2);
         end
         for (int s = 1; s <= RootSteps; s++) begin
            rv_ff[s] <= rv_ff[s-1];
            for (int v = 0; v < 3; v++) begin
               if (rn_ff[s-1][v] >= rr_ff[s-1][v] + rb_ff[s-1][v]) begin
                  rn_ff[s][v] <= rn_ff[s-1][v] - (rr_ff[s-1][v] + rb_ff[s-1][v]);
                  rr_ff[s][v] <= (rr_ff[s-1][v] >> 1) + rb_ff[s-1][v];
               end else begin
                  rn_ff[s][v] <= rn_ff[s-1][v];
                  rr_ff[s][v] <= rr_ff[s-1][v] >> 1;
               end
               rb_ff[s][v] <= rb_ff[s-1][v] >> 2;
            end
         end
         // restoring divide |c| / len, one quotient bit a stage
         ds_ff[0] <= rv_ff[RootSteps].shift;
         for (int v = 0; v < 3; v++) dl_ff[0][v] <= rr_ff[RootSteps][v][LenWidth-1:0];
         for (int i = 0; i < 3; i++) begin
            dr_ff[0][i]   <= (LenWidth+1)'(rv_ff[RootSteps].xs[i][ScaleWidth-1]
                             ? -rv_ff[RootSteps].xs[i] : rv_ff[RootSteps].xs[i]);
            dr_ff[0][3+i] <= (LenWidth+1)'(rv_ff[RootSteps].ys[i][ScaleWidth-1]
                             ? -rv_ff[RootSteps].ys[i] : rv_ff[RootSteps].ys[i]);
            dr_ff[0][6+i] <= (LenWidth+1)'(rv_ff[RootSteps].zs[i][ScaleWidth-1]
                             ? -rv_ff[RootSteps].zs[i] : rv_ff[RootSteps].zs[i]);
            dn_ff[0][i]   <= rv_ff[RootSteps].xs[i][ScaleWidth-1];
            dn_ff[0][3+i] <= rv_ff[RootSteps].ys[i][ScaleWidth-1];
            dn_ff[0][6+i] <= rv_ff[RootSteps].zs[i][ScaleWidth-1];
         end
         for (int k = 0; k < 9; k++) dq_ff[0][k] <= '0;
         for (int s = 1; s <= DivSteps; s++) begin
            ds_ff[s] <= ds_ff[s-1];
            dn_ff[s] <= dn_ff[s-1];
            for (int v = 0; v < 3; v++) dl_ff[s][v] <= dl_ff[s-1][v];
            for (int k = 0; k < 9; k++) begin
               if (dl_ff[s-1][k/3] != '0 && dr_ff[s-1][k] >= {1'b0, dl_ff[s-1][k/3]}) begin
                  dr_ff[s][k] <= (dr_ff[s-1][k] - {1'b0, dl_ff[s-1][k/3]}) << 1;
                  dq_ff[s][k] <= {dq_ff[s-1][k][QuotWidth-1:0], 1'b1};
               end else begin
                  dr_ff[s][k] <= dr_ff[s-1][k] << 1;
                  dq_ff[s][k] <= {dq_ff[s-1][k][QuotWidth-1:0], 1'b0};
               end
            end
         end
         out_ff <= out_in;
      end
   end

   // last bit is the rounding bit
   always_comb begin
      logic [QuotWidth:0] q [9];
      for (int k = 0; k < 9; k++)
         q[k] = (dq_ff[DivSteps][k] >> 1) + (QuotWidth+1)'(dq_ff[DivSteps][k][0]);
      for (int i = 0; i < 3; i++) begin
         out_in.side[i]   = dn_ff[DivSteps][i] ? -UnitWidth'(q[i]) : UnitWidth'(q[i]);
         out_in.upaxis[i] = dn_ff[DivSteps][3+i] ? -UnitWidth'(q[3+i])
                                                 : UnitWidth'(q[3+i]);
         out_in.view[i]   = dn_ff[DivSteps][6+i] ? -UnitWidth'(q[6+i])
                                                 : UnitWidth'(q[6+i]);
      end
      out_in.shift = ds_ff[DivSteps];
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_data))
      else $error("result dropped under stall");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(dvl_ff[DivSteps]))
      else $error("pipeline moved while stalled");
   a_unit: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_data.view[0] <= UnitWidth'(1 << UnitFracBits)
                 || out_data.view[0][UnitWidth-1])
      else $error("unit component out of range");
endmodule

### rtl/core/look_at_view_basis_unit.sv
// ----------------------------------------------------------------------------
// look_at_view_basis_unit
// look-at camera basis: unit side, up and view axes plus negated eye
// ----------------------------------------------------------------------------
// req channel carries eye, center and up in signed q16.16; rsp channel gives
// the three unit axes in signed q2.30 and the saturated negated eye.
// one item in, one item out, results in order.
// the front part rescales view and up and registers the item, a 4-entry
// queue parts it from the back pipeline, which forms both cross products,
// square sums, a bit-serial square root (31 stages) and nine restoring
// dividers (32 stages). throughput is one item per cycle; the back pipeline
// stalls as a whole when rsp_tready is low, the queue then absorbs what the
// front holds and req_tready falls once it is full.
// reset clears all valid flags and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module look_at_view_basis_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // eye_x, eye_y, eye_z, center_x, center_y, center_z, up_x, up_y, up_z
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // side_x..z, upaxis_x..z, view_x..z, shift_x..z
   output logic [383:0] rsp_tdata
);
   import lavb_pkg::*;

   req_type   req;
   front_type f_data, q_data;
   rsp_type   rsp;
   logic f_valid, f_ready, q_valid, q_ready;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         req.eye[i] = req_tdata[i*CoordWidth +: CoordWidth];
         req.ctr[i] = req_tdata[(3+i)*CoordWidth +: CoordWidth];
         req.up[i]  = req_tdata[(6+i)*CoordWidth +: CoordWidth];
         rsp_tdata[i*UnitWidth +: UnitWidth]     = rsp.side[i];
         rsp_tdata[(3+i)*UnitWidth +: UnitWidth] = rsp.upaxis[i];
         rsp_tdata[(6+i)*UnitWidth +: UnitWidth] = rsp.view[i];
         rsp_tdata[9*UnitWidth+i*CoordWidth +: CoordWidth] = rsp.shift[i];
      end
   end

   lavb_front u_front (.clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_data(req), .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data));
   lavb_queue u_queue (.clock, .reset, .in_valid(f_valid), .in_ready(f_ready),
      .in_data(f_data), .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data));
   lavb_back u_back (.clock, .reset, .in_valid(q_valid), .in_ready(q_ready),
      .in_data(q_data), .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(rsp));
endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for look_at_view_basis_unit
// ----------------------------------------------------------------------------
// a queue of items feeds a clocked driver on the req stream. every accepted item
// is run through a bit-true model of the camera basis, and the result goes into a
// queue of expected results. a clocked monitor checks each rsp item field by
// field against the oldest entry in that queue. both sides pause at random, and
// the rsp side holds off once for a long stretch so that the unit fills up and
// drops req_tready.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lavb_pkg::*;

   localparam int PrescaleMsb = 29;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [287:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [383:0] rsp_tdata;

   logic [287:0] pending_items[$];
   logic [383:0] basis_queue[$];
   int           errors;
   int           accepted;
   int           send_gap;
   int           stall_left;
   bit           long_hold_done;

   look_at_view_basis_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? -v : v;
   endfunction

   // block scaling: top magnitude bit moved to bit 29, right shifts truncate
   function automatic void block_scale(input longint v[3], output longint o[3]);
      longint unsigned m;
      longint unsigned a;
      int p;
      m = 0;
      p = 0;
      for (int i = 0; i < 3; i++) begin
         if (magnitude(v[i]) > m) m = magnitude(v[i]);
      end
      for (int i = 0; i < 3; i++) o[i] = 0;
      if (m != 0) begin
         while ((m >> p) > 1) p++;
         for (int i = 0; i < 3; i++) begin
            a = magnitude(v[i]);
            if (p > PrescaleMsb) a = a >> (p - PrescaleMsb);
            else a = a << (PrescaleMsb - p);
            o[i] = v[i] < 0 ? -longint'(a) : longint'(a);
         end
      end
   endfunction

   function automatic void cross_prod(input longint a[3], input longint b[3],
                                      output longint o[3]);
      o[0] = a[1] * b[2] - a[2] * b[1];
      o[1] = a[2] * b[0] - a[0] * b[2];
      o[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // unit length with round half away from zero, zero vector stays zero
   function automatic void to_unit(input longint s[3], output logic [31:0] o[3]);
      longint unsigned sum;
      longint unsigned len;
      longint unsigned r;
      longint unsigned q;
      sum = 0;
      for (int i = 0; i < 3; i++) sum += magnitude(s[i]) * magnitude(s[i]);
      for (int i = 0; i < 3; i++) o[i] = '0;
      if (sum != 0) begin
         len = floor_sqrt(sum);
         for (int i = 0; i < 3; i++) begin
            r = magnitude(s[i]);
            q = 0;
            if (r >= len) begin
               q = 1;
               r -= len;
            end
            for (int k = 0; k < UnitFracBits; k++) begin
               r = r << 1;
               q = q << 1;
               if (r >= len) begin
                  q |= 1;
                  r -= len;
               end
            end
            r = r << 1;
            if (r >= len) q += 1;
            if (s[i] < 0) q = -q;
            o[i] = q[31:0];
         end
      end
   endfunction

   function automatic logic [383:0] camera_basis(logic [287:0] item);
      longint eye[3], ctr[3], up[3], zr[3], zs[3], us[3], xr[3], xs[3], yr[3], ys[3];
      logic [31:0] xu[3], yu[3], zu[3];
      longint neg;
      logic [383:0] res;
      for (int i = 0; i < 3; i++) begin
         eye[i] = longint'($signed(item[32*i +: 32]));
         ctr[i] = longint'($signed(item[32*(3+i) +: 32]));
         up[i]  = longint'($signed(item[32*(6+i) +: 32]));
         zr[i]  = eye[i] - ctr[i];
      end
      block_scale(zr, zs);
      block_scale(up, us);
      cross_prod(us, zs, xr);
      block_scale(xr, xs);
      cross_prod(zs, xs, yr);
      block_scale(yr, ys);
      to_unit(xs, xu);
      to_unit(ys, yu);
      to_unit(zs, zu);
      for (int i = 0; i < 3; i++) begin
         neg = -eye[i];
         if (neg > 64'sd2147483647) neg = 64'sd2147483647;
         res[32*i +: 32]     = xu[i];
         res[32*(3+i) +: 32] = yu[i];
         res[32*(6+i) +: 32] = zu[i];
         res[32*(9+i) +: 32] = neg[31:0];
      end
      return res;
   endfunction

   task automatic add_item(input logic [31:0] ex, ey, ez, cx, cy, cz, ux, uy, uz);
      pending_items.push_back({uz, uy, ux, cz, cy, cx, ez, ey, ex});
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 2047) - 1024;
         2: return ($urandom_range(0, 255) - 128) << 16;
         default: return $urandom_range(0, 7) == 0 ? 32'h8000_0000 :
                                                     32'h7fff_ffff - $urandom_range(0, 3);
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // req side driver, also feeds the model on each accepted item
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap   <= 0;
         accepted   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            basis_queue.push_back(camera_basis(req_tdata));
            accepted <= accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap   <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_tdata  <= pending_items.pop_front();
               req_tvalid <= 1'b1;
               send_gap   <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // rsp side back-pressure, one long hold-off while the sender keeps going
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready     <= 1'b0;
         stall_left     <= 0;
         long_hold_done <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && accepted >= 400) begin
         long_hold_done <= 1'b1;
         stall_left     <= 300;
         rsp_tready     <= 1'b0;
      end else if (accepted > 1000 && accepted < 1300) begin
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 75) begin
         rsp_tready <= 1'b1;
      end else begin
         stall_left <= pick_gap();
         rsp_tready <= 1'b0;
      end
   end

   always @(posedge clock) begin
      logic [383:0] want;
      string names[12];
      names = '{"side_x", "side_y", "side_z", "upaxis_x", "upaxis_y", "upaxis_z",
                "view_x", "view_y", "view_z", "shift_x", "shift_y", "shift_z"};
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (basis_queue.size() == 0) begin
            $display("%0t: unexpected rsp item %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = basis_queue.pop_front();
            for (int f = 0; f < 12; f++) begin
               if (rsp_tdata[32*f +: 32] !== want[32*f +: 32]) begin
                  $display("%0t: %s expected %h actual %h", $time, names[f],
                           want[32*f +: 32], rsp_tdata[32*f +: 32]);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      #400000;
      $display("[look_at_view_basis_unit] ERROR");
      $finish;
   end

   initial begin
      logic [31:0] a, b, c;
      int drain;
      errors     = 0;
      reset      = 1'b1;
      // eye equals target, up zero, up parallel to view, saturating shift
      add_item(0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_item(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
               32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 32'h0001_0000, 0);
      add_item(0, 0, 32'h0005_0000, 0, 0, 0, 0, 0, 0);
      add_item(0, 0, 32'h0005_0000, 0, 0, 0, 0, 0, 32'h0003_0000);
      add_item(0, 0, 32'h0005_0000, 0, 0, 0, 0, 0, 32'hfffd_0000);
      add_item(0, 0, 32'h0005_0000, 0, 0, 0, 0, 32'h0001_0000, 0);
      add_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      add_item(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
               32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
               32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      add_item(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 0, 0, 0, 1, 1, 32'hffff_ffff);
      add_item(1, 0, 0, 0, 0, 0, 0, 1, 0);
      add_item(32'h8000_0000, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 0);
      add_item(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0,
               32'h8000_0000, 0, 32'h7fff_ffff);
      add_item(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0, 0, 32'h0001_0000);
      for (int n = 0; n < 1900; n++) begin
         if ($urandom_range(0, 19) == 0) begin
            // coincident eye and center points
            a = rand_coord();
            b = rand_coord();
            c = rand_coord();
            add_item(a, b, c, a, b, c, rand_coord(), rand_coord(), rand_coord());
         end else begin
            add_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     rand_coord());
         end
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (pending_items.size() == 0 && !req_tvalid);
      drain = 0;
      while (basis_queue.size() != 0 && drain < 100000) begin
         @(posedge clock);
         drain++;
      end
      repeat (200) @(posedge clock);
      if (basis_queue.size() != 0) begin
         $display("%0t: %0d expected items never arrived", $time, basis_queue.size());
         errors++;
      end
      if (errors == 0) begin
         $display("[look_at_view_basis_unit] OK");
      end else begin
         $display("[look_at_view_basis_unit] ERROR");
      end
      $finish;
   end

endmodule
